>>> hdl/psag_pkg.sv
// ----------------------------------------------------------------------------
// Paged SoA address generator package
// Shared codes and widths for the layout address generator and its checker.
// ----------------------------------------------------------------------------
package psag_pkg;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned DIV_W      = 25;
  localparam int unsigned DIV_STEP_W = $clog2(DIV_W);

  localparam logic [15:0] PAGE_SIZE_RST = 16'd1024;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGED_MODE    = 2'd0,
    CFG_PAGE_SIZE     = 2'd1,
    CFG_REQ_INSTANCES = 2'd2
  } cfg_reg_t;

endpackage

>>> hdl/paged_soa_layout_address_gen_top.sv
// ----------------------------------------------------------------------------
// Paged SoA layout address generator
// Builds a segment table of component arrays and answers byte address
// queries against it, in continuous or paged layout.
// ----------------------------------------------------------------------------
// An add aligns the running end, multiplies out its span and appends it; a query
// reads and compares the segments in turn. Paged mode adds a restoring page
// divide for the total (one bit per cycle over 25 bits), and a paged hit a second
// one for the instance. One shared multiplier and one shared adder do the rest.
// A result is loaded once the previous one has gone; the next input is taken in
// the cycle after that. Synchronous active-low reset clears count and end and resets the config.

module paged_soa_layout_address_gen_top #(
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // component, element stride, alignment, instance index, zero padding
  input  logic [psag_pkg::IN_DATA_W-1:0]     in_tdata,
  // op
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // byte_offset, total_bytes
  output logic [psag_pkg::OUT_DATA_W-1:0]    out_tdata,
  // status
  output logic [1:0]                         out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [psag_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psag_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALIGN,
    S_SPAN_MUL,
    S_APPEND,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_QDIV,
    S_QMUL_A,
    S_QADD_A,
    S_QMUL_B,
    S_QADD_B,
    S_TOT,
    S_TDIV,
    S_TMUL,
    S_DONE
  } state_t;

  state_t state_r;

  logic        paged_mode_r;
  logic [15:0] page_size_r;
  logic [23:0] req_inst_r;

  logic [CNT_W-1:0] count_r;
  logic [31:0]      end_r;
  logic [IDX_W-1:0] idx_r;

  logic [15:0] comp_r;
  logic [15:0] stride_r;
  logic [12:0] align_r;
  logic [23:0] inst_r;
  logic [31:0] base_r;
  logic [31:0] acc_r;
  logic [31:0] prod_r;
  logic [31:0] offset_r;
  logic [31:0] total_r;
  logic [1:0]  status_r;

  logic [psag_pkg::DIV_W-1:0]      quo_r;
  logic [15:0]                     rem_r;
  logic [psag_pkg::DIV_STEP_W-1:0] step_r;

  logic                            out_tvalid_r;
  logic [psag_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic [1:0]                      out_tuser_r;

  logic [15:0] seg_comp_mem   [MAX_SEGMENTS];
  logic [15:0] seg_stride_mem [MAX_SEGMENTS];
  logic [31:0] seg_base_mem   [MAX_SEGMENTS];
  logic [15:0] rd_comp_r;
  logic [15:0] rd_stride_r;
  logic [31:0] rd_base_r;

  logic [15:0] ps_eff;
  logic [31:0] page_bytes;
  logic [12:0] align_m1;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic [31:0] add_sum;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_full;
  logic [16:0] div_trial;
  logic        div_ge;
  logic [16:0] div_diff;
  logic [15:0] div_rem_nxt;
  logic        last_entry;
  logic        table_full;
  logic        out_free;
  logic [psag_pkg::DIV_W-1:0] pages_dividend;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign ps_eff     = (page_size_r == 16'd0) ? 16'd1 : page_size_r;
  assign page_bytes = (end_r + 32'd255) & ~32'd255;
  assign align_m1   = (align_r == 13'd0) ? 13'd0 : align_r - 13'd1;
  assign last_entry = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign table_full = (count_r >= CNT_W'(MAX_SEGMENTS));
  assign out_free   = !out_tvalid_r || out_tready;

  assign pages_dividend = {1'b0, req_inst_r} + {9'd0, ps_eff} - 25'd1;

  always_comb begin
    case (state_r)
      S_ALIGN: begin
        add_a = end_r;
        add_b = {19'd0, align_m1};
      end
      S_APPEND: begin
        add_a = base_r;
        add_b = prod_r;
      end
      S_QADD_A: begin
        add_a = rd_base_r;
        add_b = prod_r;
      end
      S_QADD_B: begin
        add_a = acc_r;
        add_b = prod_r;
      end
      default: begin
        add_a = 32'd0;
        add_b = 32'd0;
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  always_comb begin
    case (state_r)
      S_SPAN_MUL: begin
        mul_a = {16'd0, stride_r};
        mul_b = paged_mode_r ? {16'd0, ps_eff} : {8'd0, req_inst_r};
      end
      S_QMUL_A: begin
        mul_a = paged_mode_r ? {7'd0, quo_r} : {8'd0, inst_r};
        mul_b = paged_mode_r ? page_bytes : {16'd0, rd_stride_r};
      end
      S_QMUL_B: begin
        mul_a = {16'd0, rem_r};
        mul_b = {16'd0, rd_stride_r};
      end
      S_TMUL: begin
        mul_a = page_bytes;
        mul_b = {7'd0, quo_r};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  assign div_trial   = {rem_r, quo_r[psag_pkg::DIV_W-1]};
  assign div_ge      = (div_trial >= {1'b0, ps_eff});
  assign div_diff    = div_trial - {1'b0, ps_eff};
  assign div_rem_nxt = div_ge ? div_diff[15:0] : div_trial[15:0];

  always_ff @(posedge clk) begin
    if (state_r == S_APPEND) begin
      seg_comp_mem[count_r[IDX_W-1:0]]   <= comp_r;
      seg_stride_mem[count_r[IDX_W-1:0]] <= stride_r;
      seg_base_mem[count_r[IDX_W-1:0]]   <= base_r;
    end
    rd_comp_r   <= seg_comp_mem[idx_r];
    rd_stride_r <= seg_stride_mem[idx_r];
    rd_base_r   <= seg_base_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      paged_mode_r <= 1'b0;
      page_size_r  <= psag_pkg::PAGE_SIZE_RST;
      req_inst_r   <= 24'd0;
      count_r      <= '0;
      end_r        <= 32'd0;
      idx_r        <= '0;
      step_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          psag_pkg::CFG_PAGED_MODE:    paged_mode_r <= cfg_data[0];
          psag_pkg::CFG_PAGE_SIZE:     page_size_r  <= cfg_data[15:0];
          psag_pkg::CFG_REQ_INSTANCES: req_inst_r   <= cfg_data;
          default: ;
        endcase
      end

      if (out_tvalid_r && out_tready && (state_r != S_DONE)) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            comp_r   <= in_tdata[15:0];
            stride_r <= in_tdata[31:16];
            align_r  <= in_tdata[44:32];
            inst_r   <= in_tdata[68:45];
            offset_r <= 32'd0;
            status_r <= psag_pkg::STATUS_OK;
            idx_r    <= '0;
            if (in_tuser == psag_pkg::OP_ADD) begin
              if (table_full) begin
                status_r <= psag_pkg::STATUS_FULL;
                state_r  <= S_TOT;
              end else begin
                state_r <= S_ALIGN;
              end
            end else if (count_r == '0) begin
              status_r <= psag_pkg::STATUS_NOT_FOUND;
              state_r  <= S_TOT;
            end else begin
              state_r <= S_SEARCH_RD;
            end
          end
        end
        S_ALIGN: begin
          base_r  <= add_sum & ~{19'd0, align_m1};
          state_r <= S_SPAN_MUL;
        end
        S_SPAN_MUL: begin
          prod_r  <= mul_full[31:0];
          state_r <= S_APPEND;
        end
        S_APPEND: begin
          end_r    <= add_sum;
          count_r  <= count_r + CNT_W'(1);
          offset_r <= base_r;
          state_r  <= S_TOT;
        end
        S_SEARCH_RD: begin
          state_r <= S_SEARCH_CMP;
        end
        S_SEARCH_CMP: begin
          if (rd_comp_r == comp_r) begin
            if (paged_mode_r) begin
              quo_r   <= {1'b0, inst_r};
              rem_r   <= 16'd0;
              step_r  <= '0;
              state_r <= S_QDIV;
            end else begin
              state_r <= S_QMUL_A;
            end
          end else if (last_entry) begin
            status_r <= psag_pkg::STATUS_NOT_FOUND;
            state_r  <= S_TOT;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= S_SEARCH_RD;
          end
        end
        S_QDIV: begin
          quo_r  <= {quo_r[psag_pkg::DIV_W-2:0], div_ge};
          rem_r  <= div_rem_nxt;
          step_r <= step_r + psag_pkg::DIV_STEP_W'(1);
          if (step_r == psag_pkg::DIV_STEP_W'(psag_pkg::DIV_W - 1)) begin
            state_r <= S_QMUL_A;
          end
        end
        S_QMUL_A: begin
          prod_r  <= mul_full[31:0];
          state_r <= S_QADD_A;
        end
        S_QADD_A: begin
          if (paged_mode_r) begin
            acc_r   <= add_sum;
            state_r <= S_QMUL_B;
          end else begin
            offset_r <= add_sum;
            state_r  <= S_TOT;
          end
        end
        S_QMUL_B: begin
          prod_r  <= mul_full[31:0];
          state_r <= S_QADD_B;
        end
        S_QADD_B: begin
          offset_r <= add_sum;
          state_r  <= S_TOT;
        end
        S_TOT: begin
          if (paged_mode_r) begin
            quo_r   <= pages_dividend;
            rem_r   <= 16'd0;
            step_r  <= '0;
            state_r <= S_TDIV;
          end else begin
            total_r <= end_r;
            state_r <= S_DONE;
          end
        end
        S_TDIV: begin
          quo_r  <= {quo_r[psag_pkg::DIV_W-2:0], div_ge};
          rem_r  <= div_rem_nxt;
          step_r <= step_r + psag_pkg::DIV_STEP_W'(1);
          if (step_r == psag_pkg::DIV_STEP_W'(psag_pkg::DIV_W - 1)) begin
            state_r <= S_TMUL;
          end
        end
        S_TMUL: begin
          total_r <= mul_full[31:0];
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {total_r, offset_r};
            out_tuser_r  <= status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/psag_checker.sv
// ----------------------------------------------------------------------------
// Paged SoA address generator checker
// Port-level assertions on the streaming channels of the top level.
// ----------------------------------------------------------------------------
module psag_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [psag_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                      out_tuser
);

  // A stalled result holds its value until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // One item is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // A failed add or query reports a zero offset.
  a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != psag_pkg::STATUS_OK) |-> out_tdata[31:0] == 32'd0)
    else $error("non-zero offset on error status");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind paged_soa_layout_address_gen_top psag_checker u_psag_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> tb/paged_soa_layout_address_gen_checker.sv
// ----------------------------------------------------------------------------
// Paged SoA layout address checker
// Watches the configuration, input and result channels of the layout address
// generator. It keeps its own segment table and layout registers, predicts
// the result of every accepted input transfer and compares each result
// transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module paged_soa_layout_address_gen_checker #(
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [psag_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [psag_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]                      out_tuser,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [psag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psag_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                     fail_count,
  output int unsigned                     outstanding,
  output int unsigned                     ok_count,
  output int unsigned                     miss_count,
  output int unsigned                     full_count
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0]       offset;
    psag_pkg::status_t status;
    logic [31:0]       total;
  } address_result_t;

  logic        paged_r;
  logic [15:0] page_size_r;
  logic [23:0] req_inst_r;

  logic [15:0] seg_comp [MAX_SEGMENTS];
  logic [15:0] seg_strd [MAX_SEGMENTS];
  logic [31:0] seg_base [MAX_SEGMENTS];
  int unsigned n_segs;
  logic [31:0] run_end;

  address_result_t expected_addresses [$];
  int unsigned     errors = 0;
  int unsigned     n_ok = 0;
  int unsigned     n_miss = 0;
  int unsigned     n_full = 0;

  assign fail_count = errors;
  assign ok_count   = n_ok;
  assign miss_count = n_miss;
  assign full_count = n_full;

  function automatic logic [31:0] eff_page();
    return (page_size_r == 16'd0) ? 32'd1 : {16'd0, page_size_r};
  endfunction

  function automatic logic [31:0] padded_end();
    return (run_end + 32'd255) & ~32'd255;
  endfunction

  function automatic logic [31:0] layout_size();
    logic [31:0] ps;
    logic [31:0] cap;
    ps = eff_page();
    if (!paged_r) return run_end;
    cap = (({8'd0, req_inst_r} + ps - 32'd1) / ps) * ps;
    return padded_end() * ((cap + ps - 32'd1) / ps);
  endfunction

  function automatic address_result_t compute_address_result(
    input psag_pkg::op_t op,
    input logic [15:0]   comp,
    input logic [15:0]   stride,
    input logic [12:0]   align,
    input logic [23:0]   inst
  );
    address_result_t r;
    logic [31:0]     a;
    logic [31:0]     base;
    logic [31:0]     ps;
    logic [31:0]     span;
    int              hit;
    r.offset = 32'd0;
    r.status = psag_pkg::STATUS_OK;
    if (op == psag_pkg::OP_ADD) begin
      if (n_segs >= MAX_SEGMENTS) begin
        r.status = psag_pkg::STATUS_FULL;
      end else begin
        a    = (align == 13'd0) ? 32'd1 : {19'd0, align};
        base = (run_end + a - 32'd1) & ~(a - 32'd1);
        span = paged_r ? eff_page() : {8'd0, req_inst_r};
        seg_comp[n_segs] = comp;
        seg_strd[n_segs] = stride;
        seg_base[n_segs] = base;
        n_segs++;
        run_end  = base + {16'd0, stride} * span;
        r.offset = base;
      end
    end else begin
      hit = -1;
      for (int i = int'(n_segs) - 1; i >= 0; i--) begin
        if (seg_comp[i] == comp) hit = i;
      end
      if (hit < 0) begin
        r.status = psag_pkg::STATUS_NOT_FOUND;
      end else if (!paged_r) begin
        r.offset = seg_base[hit] + {8'd0, inst} * {16'd0, seg_strd[hit]};
      end else begin
        ps = eff_page();
        r.offset = ({8'd0, inst} / ps) * padded_end() + seg_base[hit]
                 + ({8'd0, inst} % ps) * {16'd0, seg_strd[hit]};
      end
    end
    r.total = layout_size();
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%08h, got 0x%08h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    address_result_t want;
    if (!rst_n) begin
      paged_r     = 1'b0;
      page_size_r = psag_pkg::PAGE_SIZE_RST;
      req_inst_r  = 24'd0;
      n_segs      = 0;
      run_end     = 32'd0;
      expected_addresses.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (psag_pkg::cfg_reg_t'(cfg_index))
          psag_pkg::CFG_PAGED_MODE:    paged_r     = cfg_data[0];
          psag_pkg::CFG_PAGE_SIZE:     page_size_r = cfg_data[15:0];
          psag_pkg::CFG_REQ_INSTANCES: req_inst_r  = cfg_data[23:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expected_addresses.push_back(compute_address_result(psag_pkg::op_t'(in_tuser),
          in_tdata[15:0], in_tdata[31:16], in_tdata[44:32], in_tdata[68:45]));
      end
      if (out_tvalid && out_tready) begin
        if (expected_addresses.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result, offset 0x%08h status %0d total 0x%08h",
                   $time, out_tdata[31:0], out_tuser, out_tdata[63:32]);
        end else begin
          want = expected_addresses.pop_front();
          compare_field("byte_offset", want.offset, out_tdata[31:0]);
          compare_field("status", {30'd0, want.status}, {30'd0, out_tuser});
          compare_field("total_bytes", want.total, out_tdata[63:32]);
          case (want.status)
            psag_pkg::STATUS_OK:        n_ok++;
            psag_pkg::STATUS_NOT_FOUND: n_miss++;
            default:                    n_full++;
          endcase
        end
      end
      outstanding <= expected_addresses.size();
    end
  end

endmodule

>>> tb/paged_soa_layout_address_gen_top_tb.sv
// ----------------------------------------------------------------------------
// Paged SoA layout address generator testbench
// Drives add and query transfers through a series of layout settings, first
// a directed set covering the corner cases and then random traffic, with
// bursty input and a stalling result side. The checker predicts and compares
// every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module paged_soa_layout_address_gen_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned ITEMS_PER_PASS = 119;
  localparam int unsigned RANDOM_PASSES  = 8;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [psag_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            in_tuser = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [psag_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0]                      out_tuser;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [psag_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [psag_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned ok_count;
  int unsigned miss_count;
  int unsigned full_count;

  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned settings_used = 0;
  int unsigned ready_hold = 0;
  int unsigned ready_mode = 0;
  logic [15:0] layout_ids [$];

  paged_soa_layout_address_gen_top dut (.*);

  paged_soa_layout_address_gen_checker u_layout_check (
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .ok_count    (ok_count),
    .miss_count  (miss_count),
    .full_count  (full_count),
    .*
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode <= $urandom_range(0, 2);
      ready_hold <= $urandom_range(20, 200);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped after %0d cycles with %0d results outstanding.",
             CYCLE_LIMIT, outstanding);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_item(input psag_pkg::op_t op, input logic [15:0] comp,
                           input logic [15:0] stride, input logic [12:0] align,
                           input logic [23:0] inst);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, inst, align, stride, comp};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (op == psag_pkg::OP_ADD) layout_ids.push_back(comp);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input psag_pkg::cfg_reg_t idx,
                           input logic [psag_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_layout(input logic mode, input logic [15:0] ps, input logic [23:0] req);
    drain();
    write_reg(psag_pkg::CFG_PAGED_MODE, {23'd0, mode});
    write_reg(psag_pkg::CFG_PAGE_SIZE, {8'd0, ps});
    write_reg(psag_pkg::CFG_REQ_INSTANCES, req);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_item();
    logic [15:0] comp;
    logic [12:0] align;
    logic [23:0] inst;
    comp  = 16'($urandom_range(0, 16'hFFFF));
    align = ($urandom_range(0, 4) == 0) ? 13'($urandom_range(0, 13'h1FFF))
                                         : 13'(1 << $urandom_range(0, 12));
    case ($urandom_range(0, 5))
      0:       inst = 24'hFFFFFF;
      1:       inst = 24'($urandom_range(0, 4095));
      default: inst = 24'($urandom_range(0, 24'hFFFFFF));
    endcase
    if ($urandom_range(0, 7) == 0) begin
      send_item(psag_pkg::OP_ADD, comp, 16'($urandom_range(0, 16'hFFFF)), align, inst);
    end else begin
      if ($urandom_range(0, 4) != 0) comp = layout_ids[$urandom_range(0, layout_ids.size() - 1)];
      send_item(psag_pkg::OP_QUERY, comp, 16'($urandom_range(0, 16'hFFFF)), align, inst);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    apply_layout(1'b0, 16'd1024, 24'd1000);
    send_item(psag_pkg::OP_QUERY, 16'd5, 16'd1, 13'd1, 24'd0);
    send_item(psag_pkg::OP_ADD, 16'h0000, 16'd1, 13'd1, 24'd0);
    send_item(psag_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 13'd4096, 24'hFFFFFF);
    send_item(psag_pkg::OP_ADD, 16'd7, 16'd12, 13'd0, 24'd0);
    send_item(psag_pkg::OP_ADD, 16'd9, 16'd3, 13'd12, 24'd0);
    send_item(psag_pkg::OP_ADD, 16'd7, 16'd40, 13'h1FFF, 24'd0);
    send_item(psag_pkg::OP_ADD, 16'd11, 16'd0, 13'd64, 24'd0);
    send_item(psag_pkg::OP_QUERY, 16'd7, 16'd0, 13'd0, 24'd0);
    send_item(psag_pkg::OP_QUERY, 16'd7, 16'd0, 13'd0, 24'hFFFFFF);
    send_item(psag_pkg::OP_QUERY, 16'hFFFF, 16'd0, 13'd0, 24'd1);
    send_item(psag_pkg::OP_QUERY, 16'h0000, 16'd0, 13'd0, 24'hFFFFFF);
    send_item(psag_pkg::OP_QUERY, 16'd9, 16'd0, 13'd0, 24'd100);
    send_item(psag_pkg::OP_QUERY, 16'd11, 16'd0, 13'd0, 24'd77);
    send_item(psag_pkg::OP_QUERY, 16'd1234, 16'd0, 13'd0, 24'd3);

    apply_layout(1'b1, 16'd1000, 24'd5000);
    send_item(psag_pkg::OP_QUERY, 16'd7, 16'd0, 13'd0, 24'd999);
    send_item(psag_pkg::OP_QUERY, 16'd7, 16'd0, 13'd0, 24'd1000);
    send_item(psag_pkg::OP_QUERY, 16'd9, 16'd0, 13'd0, 24'hFFFFFF);
    send_item(psag_pkg::OP_ADD, 16'd3, 16'd8, 13'd256, 24'd0);
    send_item(psag_pkg::OP_QUERY, 16'd3, 16'd0, 13'd0, 24'd2500);

    apply_layout(1'b1, 16'd0, 24'd17);
    send_item(psag_pkg::OP_QUERY, 16'd7, 16'd0, 13'd0, 24'd5);
    send_item(psag_pkg::OP_ADD, 16'd21, 16'd5, 13'd2, 24'd0);
    send_item(psag_pkg::OP_QUERY, 16'd21, 16'd0, 13'd0, 24'd9);

    for (int p = 0; p < RANDOM_PASSES; p++) begin
      case (p)
        0:       apply_layout(1'b0, 16'd1, 24'd0);
        1:       apply_layout(1'b1, 16'd0, 24'hFFFFFF);
        2:       apply_layout(1'b1, 16'hFFFF, 24'd1);
        3:       apply_layout(1'b1, 16'd1000, 24'd5000);
        4:       apply_layout(1'b0, 16'hFFFF, 24'hFFFFFF);
        5:       apply_layout(1'b1, 16'd64, 24'd300);
        default: apply_layout(1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'hFFFF)),
                              24'($urandom_range(0, 24'hFFFFFF)));
      endcase
      for (int n = 0; n < ITEMS_PER_PASS; n++) random_item();
    end

    drain();
    repeat (120) @(posedge clk);
    $display("Sent %0d transfers over %0d layout settings.", items_sent, settings_used);
    $display("Results: %0d ok, %0d component not found, %0d table full.",
             ok_count, miss_count, full_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results outstanding.", fail_count, outstanding);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/psag_pkg.sv
hdl/paged_soa_layout_address_gen_top.sv
hdl/psag_checker.sv
tb/paged_soa_layout_address_gen_checker.sv
tb/paged_soa_layout_address_gen_top_tb.sv
